// File: sv/krt_pkg.sv
// Shared constants, types and the control store of the keyed record table.
`timescale 1ns / 1ps
package krt_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int ACT_W    = 2;
	localparam int KEY_W    = 31;
	localparam int GRADE_W  = 7;
	localparam int ATT_W    = 8;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 6;
	localparam int REC_W    = KEY_W + 3 * GRADE_W + ATT_W;

	localparam logic [GRADE_W-1:0] GRADE_MAX = 7'd100;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LIST   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// Entry points of the control program.
	localparam upc_t UPC_FETCH      = 5'd0;
	localparam upc_t UPC_DISP_INS   = 5'd1;
	localparam upc_t UPC_DISP_REM   = 5'd2;
	localparam upc_t UPC_DISP_LIST  = 5'd3;
	localparam upc_t UPC_DISP_NONE  = 5'd4;
	localparam upc_t UPC_INS        = 5'd5;
	localparam upc_t UPC_INS_SCAN   = 5'd6;
	localparam upc_t UPC_INS_CHECK  = 5'd7;
	localparam upc_t UPC_INS_WRITE  = 5'd8;
	localparam upc_t UPC_REM        = 5'd9;
	localparam upc_t UPC_REM_SCAN   = 5'd10;
	localparam upc_t UPC_REM_CHECK  = 5'd11;
	localparam upc_t UPC_REM_SETUP  = 5'd12;
	localparam upc_t UPC_REM_SHIFT  = 5'd13;
	localparam upc_t UPC_REM_DONE   = 5'd14;
	localparam upc_t UPC_LIST       = 5'd15;
	localparam upc_t UPC_LIST_FIRST = 5'd16;
	localparam upc_t UPC_LIST_LOOP  = 5'd17;
	localparam upc_t UPC_LIST_DONE  = 5'd18;
	localparam upc_t UPC_FULL       = 5'd19;
	localparam upc_t UPC_DUP        = 5'd20;
	localparam upc_t UPC_EMPTY_KEY  = 5'd21;
	localparam upc_t UPC_NOTFOUND   = 5'd22;
	localparam upc_t UPC_EMPTY_ZERO = 5'd23;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_IS_INS,
		C_IS_REM,
		C_IS_LIST,
		C_FULL,
		C_EMPTY,
		C_FOUND,
		C_NFOUND,
		C_SCAN_MORE,
		C_SHIFT_MORE,
		C_LIST_MORE
	} cond_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_SCAN,
		OP_IDX_FOUND,
		OP_SHIFT,
		OP_RD_IDX,
		OP_LIST,
		OP_INSERT,
		OP_REMOVE
	} dp_op_t;

	typedef enum logic [3:0] {
		EM_NONE,
		EM_OK_NEW,
		EM_OK_FOUND,
		EM_LIST,
		EM_DUP,
		EM_FULL,
		EM_NOTFOUND,
		EM_EMPTY_KEY,
		EM_EMPTY_ZERO
	} emit_t;

	typedef struct packed {
		cond_t  cond;
		upc_t   target;
		dp_op_t op;
		emit_t  emit;
	} ucode_t;

	typedef struct packed {
		logic is_ins;
		logic is_rem;
		logic is_list;
		logic full;
		logic empty;
		logic found;
		logic scan_more;
		logic shift_more;
		logic list_more;
		logic stall;
	} dp_flags_t;

	function automatic logic [GRADE_W-1:0] clamp_grade(input logic [GRADE_W-1:0] g);
		return (g > GRADE_MAX) ? GRADE_MAX : g;
	endfunction

	function automatic ucode_t uw(input cond_t c, input upc_t t, input dp_op_t o,
			input emit_t e);
		ucode_t w;
		w.cond   = c;
		w.target = t;
		w.op     = o;
		w.emit   = e;
		return w;
	endfunction

	// Control program. A step jumps to its target when its condition holds,
	// otherwise it falls through to the next step.
	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t w;
		case (pc)
			UPC_FETCH:      w = uw(C_NEVER,      UPC_FETCH,     OP_ACCEPT,    EM_NONE);
			UPC_DISP_INS:   w = uw(C_IS_INS,     UPC_INS,       OP_NONE,      EM_NONE);
			UPC_DISP_REM:   w = uw(C_IS_REM,     UPC_REM,       OP_NONE,      EM_NONE);
			UPC_DISP_LIST:  w = uw(C_IS_LIST,    UPC_LIST,      OP_NONE,      EM_NONE);
			UPC_DISP_NONE:  w = uw(C_ALWAYS,     UPC_FETCH,     OP_NONE,      EM_NONE);
			UPC_INS:        w = uw(C_FULL,       UPC_FULL,      OP_NONE,      EM_NONE);
			UPC_INS_SCAN:   w = uw(C_SCAN_MORE,  UPC_INS_SCAN,  OP_SCAN,      EM_NONE);
			UPC_INS_CHECK:  w = uw(C_FOUND,      UPC_DUP,       OP_NONE,      EM_NONE);
			UPC_INS_WRITE:  w = uw(C_ALWAYS,     UPC_FETCH,     OP_INSERT,    EM_OK_NEW);
			UPC_REM:        w = uw(C_EMPTY,      UPC_EMPTY_KEY, OP_NONE,      EM_NONE);
			UPC_REM_SCAN:   w = uw(C_SCAN_MORE,  UPC_REM_SCAN,  OP_SCAN,      EM_NONE);
			UPC_REM_CHECK:  w = uw(C_NFOUND,     UPC_NOTFOUND,  OP_NONE,      EM_NONE);
			UPC_REM_SETUP:  w = uw(C_NEVER,      UPC_FETCH,     OP_IDX_FOUND, EM_NONE);
			UPC_REM_SHIFT:  w = uw(C_SHIFT_MORE, UPC_REM_SHIFT, OP_SHIFT,     EM_NONE);
			UPC_REM_DONE:   w = uw(C_ALWAYS,     UPC_FETCH,     OP_REMOVE,    EM_OK_FOUND);
			UPC_LIST:       w = uw(C_EMPTY,      UPC_EMPTY_ZERO, OP_NONE,     EM_NONE);
			UPC_LIST_FIRST: w = uw(C_NEVER,      UPC_FETCH,     OP_RD_IDX,    EM_NONE);
			UPC_LIST_LOOP:  w = uw(C_LIST_MORE,  UPC_LIST_LOOP, OP_LIST,      EM_LIST);
			UPC_LIST_DONE:  w = uw(C_ALWAYS,     UPC_FETCH,     OP_NONE,      EM_NONE);
			UPC_FULL:       w = uw(C_ALWAYS,     UPC_FETCH,     OP_NONE,      EM_FULL);
			UPC_DUP:        w = uw(C_ALWAYS,     UPC_FETCH,     OP_NONE,      EM_DUP);
			UPC_EMPTY_KEY:  w = uw(C_ALWAYS,     UPC_FETCH,     OP_NONE,      EM_EMPTY_KEY);
			UPC_NOTFOUND:   w = uw(C_ALWAYS,     UPC_FETCH,     OP_NONE,      EM_NOTFOUND);
			UPC_EMPTY_ZERO: w = uw(C_ALWAYS,     UPC_FETCH,     OP_NONE,      EM_EMPTY_ZERO);
			default:        w = uw(C_ALWAYS,     UPC_FETCH,     OP_NONE,      EM_NONE);
		endcase
		return w;
	endfunction

endpackage

// File: sv/krt_if.sv
// Request and result channel interfaces of the keyed record table.
`timescale 1ns / 1ps
interface krt_in_if import krt_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [KEY_W-1:0]    key;
	logic [GRADE_W-1:0]  grade_first;
	logic [GRADE_W-1:0]  grade_second;
	logic [GRADE_W-1:0]  grade_third;
	logic [ATT_W-1:0]    attendance;

	modport source (output valid, action, key, grade_first, grade_second, grade_third,
		attendance, input ready);
	modport sink (input valid, action, key, grade_first, grade_second, grade_third,
		attendance, output ready);
endinterface

interface krt_out_if import krt_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;
	logic [KEY_W-1:0]    record_key;
	logic [GRADE_W-1:0]  out_grade_first;
	logic [GRADE_W-1:0]  out_grade_second;
	logic [GRADE_W-1:0]  out_grade_third;
	logic [ATT_W-1:0]    out_attendance;
	logic                last;

	modport source (output valid, status, position, record_key, out_grade_first,
		out_grade_second, out_grade_third, out_attendance, last, input ready);
	modport sink (input valid, status, position, record_key, out_grade_first,
		out_grade_second, out_grade_third, out_attendance, last, output ready);
endinterface

// File: sv/krt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module krt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: sv/krt_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
module krt_seq import krt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_flags_t flags,
	output ucode_t    ctrl
);
	upc_t pc_q;
	upc_t pc_next;
	logic taken;

	assign ctrl = ucode_rom(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:      taken = 1'b0;
			C_ALWAYS:     taken = 1'b1;
			C_IS_INS:     taken = flags.is_ins;
			C_IS_REM:     taken = flags.is_rem;
			C_IS_LIST:    taken = flags.is_list;
			C_FULL:       taken = flags.full;
			C_EMPTY:      taken = flags.empty;
			C_FOUND:      taken = flags.found;
			C_NFOUND:     taken = !flags.found;
			C_SCAN_MORE:  taken = flags.scan_more;
			C_SHIFT_MORE: taken = flags.shift_more;
			C_LIST_MORE:  taken = flags.list_more;
			default:      taken = 1'b0;
		endcase

		if (flags.stall) begin
			pc_next = pc_q;
		end else if (taken) begin
			pc_next = ctrl.target;
		end else begin
			pc_next = pc_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UPC_FETCH;
		end else begin
			pc_q <= pc_next;
		end
	end
endmodule

// File: sv/krt_dp.sv
// Datapath: item latch, entry table, scan and shift indexes, result register.
`timescale 1ns / 1ps
module krt_dp import krt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	krt_in_if.sink    req,
	krt_out_if.source rsp,
	input  ucode_t    ctrl,
	output dp_flags_t flags
);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Latched item.
	logic [ACT_W-1:0]   act_q;
	logic [KEY_W-1:0]   key_q;
	logic [GRADE_W-1:0] g1_q, g2_q, g3_q;
	logic [ATT_W-1:0]   att_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] fpos_q;
	logic [CNT_W-1:0] pos_s1;
	logic             found_q;
	logic             rdv_s1;

	logic                out_full_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    position_q;
	logic [KEY_W-1:0]    rkey_q;
	logic [GRADE_W-1:0]  og1_q, og2_q, og3_q;
	logic [ATT_W-1:0]    oatt_q;
	logic                last_q;

	logic             we, re;
	logic [IDX_W-1:0] waddr, raddr;
	logic [REC_W-1:0] wdata, rdata;

	logic [CNT_W:0]     idx_nxt;
	logic               more_after;
	logic               at_end;
	logic [KEY_W-1:0]   rd_key;
	logic [GRADE_W-1:0] rd_g1, rd_g2, rd_g3;
	logic [ATT_W-1:0]   rd_att;
	logic               hit;
	logic               stall, go, load;

	logic [STATUS_W-1:0] e_status;
	logic [POS_W-1:0]    e_pos;
	logic [KEY_W-1:0]    e_key;
	logic [GRADE_W-1:0]  e_g1, e_g2, e_g3;
	logic [ATT_W-1:0]    e_att;
	logic                e_last;

	krt_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_key = rdata[REC_W-1 -: KEY_W];
	assign rd_g3  = rdata[ATT_W + 3*GRADE_W - 1 -: GRADE_W];
	assign rd_g2  = rdata[ATT_W + 2*GRADE_W - 1 -: GRADE_W];
	assign rd_g1  = rdata[ATT_W + GRADE_W - 1 -: GRADE_W];
	assign rd_att = rdata[ATT_W-1:0];

	assign idx_nxt    = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};
	assign more_after = idx_nxt < {1'b0, count_q};
	assign at_end     = (idx_q == count_q);
	assign hit        = rdv_s1 && (rd_key == key_q);

	assign stall = ((ctrl.op == OP_ACCEPT) && !req.valid) ||
		((ctrl.emit != EM_NONE) && out_full_q && !rsp.ready);
	assign go    = !stall;
	assign load  = go && (ctrl.emit != EM_NONE);

	assign req.ready = (ctrl.op == OP_ACCEPT);

	// At most one read and at most one write per cycle on the entry table.
	always_comb begin
		re    = 1'b0;
		raddr = idx_q[IDX_W-1:0];
		we    = 1'b0;
		waddr = count_q[IDX_W-1:0];
		wdata = {key_q, g3_q, g2_q, g1_q, att_q};
		case (ctrl.op)
			OP_SCAN: begin
				re = go && !at_end;
			end
			OP_SHIFT: begin
				re    = go && more_after;
				raddr = idx_nxt[IDX_W-1:0];
				we    = go && rdv_s1;
				waddr = pos_s1[IDX_W-1:0];
				wdata = rdata;
			end
			OP_RD_IDX: begin
				re = go;
			end
			OP_LIST: begin
				re    = go && more_after;
				raddr = idx_nxt[IDX_W-1:0];
			end
			OP_INSERT: begin
				we = go;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			fpos_q  <= '0;
			pos_s1  <= '0;
			found_q <= 1'b0;
			rdv_s1  <= 1'b0;
		end else if (go) begin
			case (ctrl.op)
				OP_ACCEPT: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					rdv_s1  <= 1'b0;
				end
				OP_SCAN: begin
					// A compare happens in the cycle after its read.
					if (hit) begin
						found_q <= 1'b1;
						fpos_q  <= pos_s1;
					end
					if (!at_end) begin
						idx_q  <= idx_nxt[CNT_W-1:0];
						pos_s1 <= idx_q;
					end
					rdv_s1 <= !at_end && !hit;
				end
				OP_IDX_FOUND: begin
					idx_q  <= fpos_q;
					rdv_s1 <= 1'b0;
				end
				OP_SHIFT: begin
					// Entry idx+1 is read now and written to entry idx next cycle.
					if (more_after) begin
						idx_q  <= idx_nxt[CNT_W-1:0];
						pos_s1 <= idx_q;
					end
					rdv_s1 <= more_after;
				end
				OP_LIST: begin
					idx_q  <= idx_nxt[CNT_W-1:0];
					rdv_s1 <= 1'b0;
				end
				OP_INSERT: begin
					count_q <= count_q + {{(CNT_W-1){1'b0}}, 1'b1};
					rdv_s1  <= 1'b0;
				end
				OP_REMOVE: begin
					count_q <= count_q - {{(CNT_W-1){1'b0}}, 1'b1};
					rdv_s1  <= 1'b0;
				end
				default: begin
					rdv_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go && (ctrl.op == OP_ACCEPT)) begin
			act_q <= req.action;
			key_q <= req.key;
			g1_q  <= clamp_grade(req.grade_first);
			g2_q  <= clamp_grade(req.grade_second);
			g3_q  <= clamp_grade(req.grade_third);
			att_q <= req.attendance;
		end
	end

	always_comb begin
		e_status = ST_OK;
		e_pos    = '0;
		e_key    = key_q;
		e_g1     = '0;
		e_g2     = '0;
		e_g3     = '0;
		e_att    = '0;
		e_last   = 1'b1;
		case (ctrl.emit)
			EM_OK_NEW: begin
				e_pos = POS_W'(count_q);
			end
			EM_OK_FOUND: begin
				e_pos = POS_W'(fpos_q);
			end
			EM_LIST: begin
				e_pos  = POS_W'(idx_q);
				e_key  = rd_key;
				e_g1   = rd_g1;
				e_g2   = rd_g2;
				e_g3   = rd_g3;
				e_att  = rd_att;
				e_last = !more_after;
			end
			EM_DUP: begin
				e_status = ST_DUP;
			end
			EM_FULL: begin
				e_status = ST_FULL;
			end
			EM_NOTFOUND: begin
				e_status = ST_NOTFOUND;
			end
			EM_EMPTY_KEY: begin
				e_status = ST_EMPTY;
			end
			EM_EMPTY_ZERO: begin
				e_status = ST_EMPTY;
				e_key    = '0;
			end
			default: begin
				e_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (load) begin
			out_full_q <= 1'b1;
		end else if (rsp.ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q   <= e_status;
			position_q <= e_pos;
			rkey_q     <= e_key;
			og1_q      <= e_g1;
			og2_q      <= e_g2;
			og3_q      <= e_g3;
			oatt_q     <= e_att;
			last_q     <= e_last;
		end
	end

	assign rsp.valid            = out_full_q;
	assign rsp.status           = status_q;
	assign rsp.position         = position_q;
	assign rsp.record_key       = rkey_q;
	assign rsp.out_grade_first  = og1_q;
	assign rsp.out_grade_second = og2_q;
	assign rsp.out_grade_third  = og3_q;
	assign rsp.out_attendance   = oatt_q;
	assign rsp.last             = last_q;

	assign flags.is_ins     = (act_q == ACT_INSERT);
	assign flags.is_rem     = (act_q == ACT_REMOVE);
	assign flags.is_list    = (act_q == ACT_LIST);
	assign flags.full       = (count_q == CNT_W'(CAPACITY));
	assign flags.empty      = (count_q == '0);
	assign flags.found      = found_q;
	assign flags.scan_more  = !hit && !(at_end && !rdv_s1);
	assign flags.shift_more = more_after || rdv_s1;
	assign flags.list_more  = more_after;
	assign flags.stall      = stall;
endmodule

// File: sv/keyed_record_table_top.sv
// Top level of the keyed record table: sequencer, datapath and checks.
`timescale 1ns / 1ps
// The table keeps up to CAPACITY records (key, three grades, attendance) in
// arrival order in a single-port-read RAM, and a short microprogram walks it
// one entry per cycle. Insert runs a linear key search, then an append;
// remove searches up to the key, then shifts the later entries down one
// place; list gives one result per cycle while the result side keeps
// taking them. The single RAM read port is why the entries are walked one
// at a time. Results pass through a one-item output register, and the
// block takes the next item only when the previous one has been fully
// handled. Unused action codes are taken and dropped without any result.
module keyed_record_table_top import krt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	krt_in_if.sink    req,
	krt_out_if.source rsp
);
	ucode_t    ctrl;
	dp_flags_t flags;

	krt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	krt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctrl   (ctrl),
		.flags  (flags)
	);

	// An accepted item is worked on before another one is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken again right after an accepted item");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(flags.full && flags.empty))
		else $error("table reported both full and empty");

	// Entries are only shifted down after the search found the key.
	a_shift_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_SHIFT) |-> flags.found)
		else $error("shift started without a key match");
endmodule
